FILE: hdl/sfrc_pkg.sv
// Package for the serial frame receiver with CRC-16 check.
// Holds widths, register indexes, reset values, shared structs and the CRC byte update.
// No dependencies.
package sfrc_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_PAYLOAD = 8;
    localparam int LEN_W       = 4;
    localparam int LANE_IDX_W  = $clog2(MAX_PAYLOAD);
    localparam int PAYLOAD_W   = MAX_PAYLOAD * BYTE_W;
    localparam int CRC_W       = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE = 2'd2;

    localparam logic [BYTE_W-1:0] HEAD_CODE_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] CMD_CODE_RST  = 8'h01;
    localparam logic [BYTE_W-1:0] DATA_CODE_RST = 8'h02;

    typedef struct packed {
        logic [BYTE_W-1:0] head_code;
        logic [BYTE_W-1:0] command_type_code;
        logic [BYTE_W-1:0] data_type_code;
    } sfrc_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    frame_kind;
        logic [LEN_W-1:0]     payload_len;
        logic [PAYLOAD_W-1:0] payload_bytes;
    } sfrc_result_t;

    // Reflected CRC-16 update over one byte, bit by bit
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

FILE: hdl/sfrc_cfg_regs.sv
// Configuration registers of the frame receiver: head, command and data type codes.
// Depends on sfrc_pkg.
module sfrc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sfrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfrc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sfrc_pkg::sfrc_cfg_t                cfg
);
    import sfrc_pkg::*;

    sfrc_cfg_t cfg_reg;
    sfrc_cfg_t cfg_next;

    // Decode the write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAD_CODE: cfg_next.head_code         = cfg_data;
                CFG_CMD_CODE:  cfg_next.command_type_code = cfg_data;
                CFG_DATA_CODE: cfg_next.data_type_code    = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_code         <= HEAD_CODE_RST;
            cfg_reg.command_type_code <= CMD_CODE_RST;
            cfg_reg.data_type_code    <= DATA_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/sfrc_parser.sv
// Frame parser: phase sequencer, payload lanes and running CRC-16.
// Flags a result combinationally on the CRC low byte when the CRC matches. Depends on sfrc_pkg.
module sfrc_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_take,
    input  logic [sfrc_pkg::BYTE_W-1:0]  rx_byte,
    input  sfrc_pkg::sfrc_cfg_t          cfg,
    output logic                         res_valid,
    output sfrc_pkg::sfrc_result_t       res
);
    import sfrc_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LEN_H = 3'd2;
    localparam logic [2:0] PH_LEN_L = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRC_H = 3'd5;
    localparam logic [2:0] PH_CRC_L = 3'd6;
    localparam logic [2:0] PH_TAIL  = 3'd7;

    logic [2:0]        phase_reg,   phase_next;
    logic [LEN_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0] len_hi_reg,  len_hi_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic [BYTE_W-1:0] kind_reg,    kind_next;
    logic [CRC_W-1:0]  crc_reg,     crc_next;
    logic [BYTE_W-1:0] crc_hi_reg,  crc_hi_next;
    logic [BYTE_W-1:0] store_reg [MAX_PAYLOAD];

    logic [LEN_W-1:0]  count_inc;
    logic              len_too_big;
    logic              store_we;

    assign count_inc   = count_reg + LEN_W'(1);
    assign len_too_big = (len_hi_reg != '0) || (rx_byte > BYTE_W'(MAX_PAYLOAD));
    assign store_we    = byte_take && (phase_reg == PH_DATA);

    // Advance the phase sequencer on each accepted word
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_hi_next = len_hi_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        res_valid   = 1'b0;
        if (byte_take)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == cfg.head_code)
                    begin
                        phase_next = PH_TYPE;
                        count_next = '0;
                        crc_next   = CRC_INIT;
                    end
                end
                PH_TYPE:
                begin
                    if ((rx_byte == cfg.command_type_code) || (rx_byte == cfg.data_type_code))
                    begin
                        kind_next  = rx_byte;
                        phase_next = PH_LEN_H;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN_H:
                begin
                    len_hi_next = rx_byte;
                    phase_next  = PH_LEN_L;
                end
                PH_LEN_L:
                begin
                    len_next = rx_byte[LEN_W-1:0];
                    if (len_too_big)
                        phase_next = PH_IDLE;
                    else if (rx_byte == '0)
                        phase_next = PH_CRC_H;
                    else
                        phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    crc_next   = crc_feed(crc_reg, rx_byte);
                    count_next = count_inc;
                    if (count_inc >= len_reg)
                        phase_next = PH_CRC_H;
                end
                PH_CRC_H:
                begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRC_L;
                end
                PH_CRC_L:
                begin
                    res_valid  = ({crc_hi_reg, rx_byte} == crc_reg);
                    phase_next = PH_TAIL;
                end
                PH_TAIL:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Pack the payload lanes, zero above the frame length
    always_comb
    begin
        res.frame_kind  = kind_reg;
        res.payload_len = len_reg;
        for (int i = 0; i < MAX_PAYLOAD; i++)
        begin
            if (LEN_W'(i) < len_reg)
                res.payload_bytes[i*BYTE_W +: BYTE_W] = store_reg[i];
            else
                res.payload_bytes[i*BYTE_W +: BYTE_W] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            len_hi_reg <= '0;
            len_reg    <= '0;
            kind_reg   <= '0;
            crc_reg    <= CRC_INIT;
            crc_hi_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            crc_reg    <= crc_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

    // Write the payload lane picked by the byte count
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[count_reg[LANE_IDX_W-1:0]] <= rx_byte;
    end

endmodule

FILE: hdl/sfrc_out_buf.sv
// Result register with one skid entry for the frame receiver output channel.
// Depends on sfrc_pkg.
module sfrc_out_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  sfrc_pkg::sfrc_result_t  res,
    output logic                    full,
    output logic                    out_valid,
    input  logic                    out_stall,
    output sfrc_pkg::sfrc_result_t  out_word
);
    import sfrc_pkg::*;

    logic         out_valid_reg,  out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    sfrc_result_t out_reg,        out_next;
    sfrc_result_t skid_reg,       skid_next;
    logic         out_fire;

    assign out_fire = out_valid_reg && !out_stall;

    // Move the skid entry forward first, else load or park a new result, else clear valid once taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: hdl/serial_frame_receiver_crc16.sv
// Serial frame receiver with CRC-16 check: top level.
// Instantiates sfrc_cfg_regs, sfrc_parser and sfrc_out_buf; depends on sfrc_pkg.
//
// Usage:
//   Input channel: one received word (rx_byte) per handshake, taken on a rising
//   edge with in_valid high and in_stall low. Frames are head, type, 16-bit
//   length, 0..8 payload words, 16-bit CRC (reflected CRC-16, poly 0xA001,
//   start 0xFFFF, over the payload) and a tail word that is always consumed.
//   Output channel: one word per good frame (frame_kind, payload_len,
//   payload_bytes), taken with out_valid high and out_stall low.
//   Throughput: one input word per cycle while in_stall is low; the parser
//   updates state and CRC in the same cycle a word is taken.
//   Result: registered into the output register, or into the skid entry if
//   the output is still held, as the CRC low word is taken.
//   Stall: a result register plus one skid entry hold pending results; in_stall
//   rises only while the skid entry is occupied.
//   Reset: parser to idle, CRC to 0xFFFF, output empty, configuration codes to
//   head 0xAA, command 0x01, data 0x02. Configuration writes via cfg_we take
//   effect from the next word.
module serial_frame_receiver_crc16 (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sfrc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfrc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sfrc_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sfrc_pkg::BYTE_W-1:0]          frame_kind,
    output logic [sfrc_pkg::LEN_W-1:0]           payload_len,
    output logic [sfrc_pkg::PAYLOAD_W-1:0]       payload_bytes
);
    import sfrc_pkg::*;

    sfrc_cfg_t    cfg;
    sfrc_result_t res;
    sfrc_result_t out_word;
    logic         res_valid;
    logic         buf_full;
    logic         byte_take;

    // Take a word whenever the skid entry is free
    assign in_stall  = buf_full;
    assign byte_take = in_valid && !buf_full;

    sfrc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfrc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfrc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign frame_kind    = out_word.frame_kind;
    assign payload_len   = out_word.payload_len;
    assign payload_bytes = out_word.payload_bytes;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for serial_frame_receiver_crc16: directed and random byte streams with idle gaps
// and output stalls, checked against a cycle-free frame parser kept in the bench.
// Depends on sfrc_pkg and the serial_frame_receiver_crc16 RTL.
module tb_top;
    import sfrc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS  = 250;
    localparam int PHASE_WORDS   = 150;
    localparam int MAX_REPORTS   = 50;

    // Index beyond the last register; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef enum logic [2:0] {
        WAIT_HEAD,
        GET_KIND,
        GET_LEN_HI,
        GET_LEN_LO,
        GET_PAYLOAD,
        GET_CRC_HI,
        GET_CRC_LO,
        SKIP_TAIL
    } parse_phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [BYTE_W-1:0]      frame_kind;
    logic [LEN_W-1:0]       payload_len;
    logic [PAYLOAD_W-1:0]   payload_bytes;

    // Parser copy: codes, phase and frame contents
    logic [7:0]             code_head;
    logic [7:0]             code_cmd;
    logic [7:0]             code_data;
    parse_phase_t           phase;
    logic [3:0]             byte_cnt;
    logic [15:0]            frame_len;
    logic [7:0]             kind_q;
    logic [7:0]             lane_store [MAX_PAYLOAD];
    logic [15:0]            crc_acc;
    logic [7:0]             crc_hi;

    // Good frames predicted but not yet seen at the output
    sfrc_result_t           pending_frames [$];
    sfrc_result_t           oldest_frame;

    int                     error_count;
    int                     words_sent;
    int                     noise_words;
    int                     in_idle_max;
    int                     out_idle_max;
    int                     stall_left;

    serial_frame_receiver_crc16 u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_kind    (frame_kind),
        .payload_len   (payload_len),
        .payload_bytes (payload_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC-16, one data bit at a time, LSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void reset_parser();
        code_head = HEAD_CODE_RST;
        code_cmd  = CMD_CODE_RST;
        code_data = DATA_CODE_RST;
        phase     = WAIT_HEAD;
        byte_cnt  = '0;
        frame_len = '0;
        kind_q    = '0;
        crc_acc   = CRC_INIT;
        crc_hi    = '0;
        for (int i = 0; i < MAX_PAYLOAD; i++)
            lane_store[i] = '0;
    endfunction

    // Advance the parser copy by one accepted word; queue a frame on a CRC match
    function automatic void parse_rx_byte(input logic [7:0] b);
        sfrc_result_t frame;
        logic [63:0]  lanes;
        case (phase)
            WAIT_HEAD:
            begin
                if (b == code_head)
                begin
                    phase    = GET_KIND;
                    byte_cnt = '0;
                    crc_acc  = CRC_INIT;
                end
            end
            GET_KIND:
            begin
                if (b == code_cmd || b == code_data)
                begin
                    kind_q = b;
                    phase  = GET_LEN_HI;
                end
                else
                    phase = WAIT_HEAD;
            end
            GET_LEN_HI:
            begin
                frame_len = {b, 8'h00};
                phase     = GET_LEN_LO;
            end
            GET_LEN_LO:
            begin
                frame_len = frame_len | {8'h00, b};
                if (frame_len > MAX_PAYLOAD)
                    phase = WAIT_HEAD;
                else if (frame_len == 0)
                    phase = GET_CRC_HI;
                else
                    phase = GET_PAYLOAD;
            end
            GET_PAYLOAD:
            begin
                lane_store[byte_cnt[2:0]] = b;
                crc_acc  = crc16_step(crc_acc, b);
                byte_cnt = byte_cnt + 4'd1;
                if (byte_cnt >= frame_len)
                    phase = GET_CRC_HI;
            end
            GET_CRC_HI:
            begin
                crc_hi = b;
                phase  = GET_CRC_LO;
            end
            GET_CRC_LO:
            begin
                if ({crc_hi, b} == crc_acc)
                begin
                    lanes = '0;
                    for (int i = 0; i < MAX_PAYLOAD; i++)
                        if (i < frame_len)
                            lanes[8*i +: 8] = lane_store[i];
                    frame.frame_kind    = kind_q;
                    frame.payload_len   = frame_len[LEN_W-1:0];
                    frame.payload_bytes = lanes;
                    pending_frames.push_back(frame);
                end
                phase = SKIP_TAIL;
            end
            default:
                phase = WAIT_HEAD;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // Send one word; valid stays high on return so back-to-back words need no lowering
    task automatic send_word(input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (in_stall);
        parse_rx_byte(value);
        words_sent++;
    endtask

    // Drop valid, wait until every predicted frame is out, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_code(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_HEAD_CODE: code_head = value;
            CFG_CMD_CODE:  code_cmd  = value;
            CFG_DATA_CODE: code_data = value;
            default: ;
        endcase
    endtask

    task automatic write_codes(input logic [7:0] head, input logic [7:0] cmd,
                               input logic [7:0] data);
        drain();
        put_code(CFG_HEAD_CODE, head);
        put_code(CFG_CMD_CODE, cmd);
        put_code(CFG_DATA_CODE, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Send a frame; stop after the type word for an unknown type and after the
    // length for an oversize length, as the parser drops out there anyway
    task automatic send_frame(input logic [7:0] kind, input logic [15:0] len,
                              input logic [63:0] data, input bit spoil_crc);
        logic [15:0] crc;
        crc = CRC_INIT;
        if (len <= MAX_PAYLOAD)
            for (int i = 0; i < len; i++)
                crc = crc16_step(crc, data[8*i +: 8]);
        if (spoil_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        // Switch between idling and full-rate stretches now and then
        if ($urandom_range(0, 7) == 0)
            in_idle_max = $urandom_range(0, 1) ? 12 : 0;
        if ($urandom_range(0, 7) == 0)
            out_idle_max = $urandom_range(0, 1) ? 12 : 0;
        send_word(code_head);
        send_word(kind);
        if (kind != code_cmd && kind != code_data)
            return;
        send_word(len[15:8]);
        send_word(len[7:0]);
        if (len > MAX_PAYLOAD)
            return;
        for (int i = 0; i < len; i++)
            send_word(data[8*i +: 8]);
        send_word(crc[15:8]);
        send_word(crc[7:0]);
        send_word(8'($urandom_range(0, 255)));
    endtask

    // Mostly good frames with random content, the rest broken frames and line noise
    task automatic send_random_frame();
        int          pick;
        int          n;
        logic [7:0]  kind;
        logic [15:0] len;
        logic [63:0] data;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? code_cmd : code_data;
        len  = 16'($urandom_range(0, MAX_PAYLOAD));
        data = {$urandom, $urandom};
        if (pick < 70)
            send_frame(kind, len, data, 1'b0);
        else if (pick < 80)
            send_frame(kind, len, data, 1'b1);
        else if (pick < 85)
        begin
            do
                kind = 8'($urandom_range(0, 255));
            while (kind == code_cmd || kind == code_data);
            send_frame(kind, len, data, 1'b0);
        end
        else if (pick < 92)
        begin
            case ($urandom_range(0, 2))
                0: len = 16'($urandom_range(MAX_PAYLOAD + 1, 255));
                1: len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, MAX_PAYLOAD))};
                default: len = 16'hFFFF;
            endcase
            send_frame(kind, len, data, 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                do
                    kind = 8'($urandom_range(0, 255));
                while (kind == code_head);
                send_word(kind);
                noise_words++;
            end
        end
    endtask

    task automatic run_random_words(input int count);
        int start_words;
        int start_noise;
        start_words = words_sent;
        start_noise = noise_words;
        while (words_sent - start_words < count + (noise_words - start_noise))
            send_random_frame();
    endtask

    // Extremes, every type, and each way a frame can be dropped under reset codes
    task automatic test_directed_frames();
        send_word(8'h00);
        send_frame(code_cmd, 16'd0, 64'h0, 1'b0);
        send_frame(code_data, 16'd8, 64'h00FF_AA02_01AA_FF00, 1'b0);
        send_frame(code_cmd, 16'd1, 64'hFF, 1'b0);
        send_frame(code_data, 16'd3, 64'h12_3456, 1'b1);
        // Unknown type equal to the head code is not taken as a new head
        send_word(code_head);
        send_word(code_head);
        send_frame(code_data, 16'd2, 64'hAAAA, 1'b0);
        send_frame(code_cmd, 16'd9, 64'h0, 1'b0);
        send_frame(code_data, 16'h0100, 64'h0, 1'b0);
        send_frame(code_cmd, 16'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        drain();
    endtask

    task automatic test_random_frames();
        run_random_words(RANDOM_WORDS);
        drain();
    endtask

    // Zero-length frames at full input rate against long output stalls fill the skid entry
    task automatic test_output_backpressure();
        int saved_in;
        int saved_out;
        saved_in     = in_idle_max;
        saved_out    = out_idle_max;
        in_idle_max  = 0;
        out_idle_max = 12;
        for (int i = 0; i < 20; i++)
        begin
            send_word(code_head);
            send_word(code_cmd);
            send_word(8'h00);
            send_word(8'h00);
            send_word(8'hFF);
            send_word(8'hFF);
            send_word(8'h00);
        end
        drain();
        in_idle_max  = saved_in;
        out_idle_max = saved_out;
    endtask

    // Run random traffic under extreme and random codes, then return to reset codes
    task automatic test_code_settings();
        write_codes(8'h00, 8'h00, 8'hFF);
        run_random_words(PHASE_WORDS);
        write_codes(8'hFF, 8'hFF, 8'h00);
        run_random_words(PHASE_WORDS);
        // Spare index must leave all codes alone
        drain();
        put_code(CFG_SPARE_IDX, 8'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
        @(posedge clk);
        run_random_words(PHASE_WORDS);
        write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        run_random_words(PHASE_WORDS);
        write_codes(HEAD_CODE_RST, CMD_CODE_RST, DATA_CODE_RST);
        run_random_words(PHASE_WORDS);
        drain();
    endtask

    // Check each accepted result against the oldest pending frame
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
                report_mismatch("result with no frame pending", 64'(frame_kind), 64'h0);
            else
            begin
                oldest_frame = pending_frames.pop_front();
                if (frame_kind !== oldest_frame.frame_kind)
                    report_mismatch("frame_kind", 64'(frame_kind),
                                    64'(oldest_frame.frame_kind));
                if (payload_len !== oldest_frame.payload_len)
                    report_mismatch("payload_len", 64'(payload_len),
                                    64'(oldest_frame.payload_len));
                if (payload_bytes !== oldest_frame.payload_bytes)
                    report_mismatch("payload_bytes", payload_bytes,
                                    oldest_frame.payload_bytes);
            end
        end
    end

    // Hold off the output for a drawn number of cycles after a result, or at random
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            if (stall_left == 0)
                out_stall <= 1'b0;
        end
        else if ((out_valid && !out_stall) || $urandom_range(0, 15) == 0)
        begin
            stall_left = $urandom_range(0, out_idle_max);
            if (stall_left > 0)
                out_stall <= 1'b1;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        rx_byte      <= '0;
        out_stall    <= 1'b0;
        stall_left   = 0;
        error_count  = 0;
        words_sent   = 0;
        noise_words  = 0;
        in_idle_max  = 12;
        out_idle_max = 12;
        reset_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_frames();
        test_output_backpressure();
        test_code_settings();

        drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
